// ===== sv/cfau_pkg.sv =====
// Shared types and constants of the complex fixed-point arithmetic unit.
package cfau_pkg;

  // Field widths fixed by the port list.
  localparam int FIELD_W = 16;
  localparam int OUT_W   = 33;
  localparam int FRAC_W  = 6;
  localparam int REG_W   = 5;
  localparam int IDX_W   = 2;

  // Register indexes of the configuration channel.
  localparam logic [IDX_W-1:0] REG_LHS_FRAC = 2'd0;
  localparam logic [IDX_W-1:0] REG_RHS_FRAC = 2'd1;

  // Reset value of both fraction-bit registers.
  localparam logic [REG_W-1:0] FRAC_RESET = 5'd8;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Control word that travels with every beat down the pipeline.
  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [FRAC_W-1:0] frac;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
  } ctrl_t;

endpackage

// ===== sv/cfau_front.sv =====
// Front stages: products and alignment, sums, then magnitudes and divider setup.
module cfau_front
  import cfau_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  cmd_t                  cmd,
  input  logic signed [W-1:0]   ar,
  input  logic signed [W-1:0]   ai,
  input  logic signed [W-1:0]   br,
  input  logic signed [W-1:0]   bi,
  input  logic [REG_W-1:0]      lf,
  input  logic [REG_W-1:0]      rf,
  output ctrl_t                 ctrl,
  output logic signed [2*W:0]   direct_re,
  output logic signed [2*W:0]   direct_im,
  output logic [2*W-1:0]        rem_re,
  output logic [2*W-1:0]        rem_im,
  output logic [2*W-1:0]        rest_re,
  output logic [2*W-1:0]        rest_im,
  output logic [2*W-1:0]        den
);

  localparam int RW = 2 * W + 1;
  localparam int PW = 2 * W;

  // Stage A: products, aligned operands and the result format.
  ctrl_t                a_ctrl;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, p_bbr, p_bbi;
  logic signed [RW-1:0] x_r, x_i, y_r, y_i;
  logic [REG_W-1:0]     mf;
  logic [REG_W-1:0]     ls, rs;
  logic [FRAC_W-1:0]    frac_a;

  always_comb begin
    mf = (lf > rf) ? lf : rf;
    ls = mf - lf;
    rs = mf - rf;
    case (cmd)
      CMD_ADD, CMD_SUB: frac_a = FRAC_W'(mf);
      CMD_MUL:          frac_a = FRAC_W'({2'b00, lf} + {2'b00, rf});
      default:          frac_a = FRAC_W'({2'b00, lf} + 7'(W) - {2'b00, rf});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl.valid <= 1'b0;
    end else begin
      a_ctrl.valid <= in_valid;
    end
    a_ctrl.cmd    <= cmd;
    a_ctrl.frac   <= frac_a;
    a_ctrl.dz     <= 1'b0;
    a_ctrl.neg_re <= 1'b0;
    a_ctrl.neg_im <= 1'b0;
    p_rr  <= ar * br;
    p_ii  <= ai * bi;
    p_ir  <= ai * br;
    p_ri  <= ar * bi;
    p_bbr <= br * br;
    p_bbi <= bi * bi;
    x_r   <= RW'(ar) << ls;
    x_i   <= RW'(ai) << ls;
    y_r   <= RW'(br) << rs;
    y_i   <= RW'(bi) << rs;
  end

  // Stage B: numerators, divisor and the non-divide result.
  ctrl_t                b_ctrl;
  logic signed [RW-1:0] b_nr, b_ni, b_dre, b_dim;
  logic [PW-1:0]        b_den;
  logic signed [RW-1:0] dre_next, dim_next;

  always_comb begin
    case (a_ctrl.cmd)
      CMD_ADD: begin
        dre_next = x_r + y_r;
        dim_next = x_i + y_i;
      end
      CMD_SUB: begin
        dre_next = x_r - y_r;
        dim_next = x_i - y_i;
      end
      default: begin
        dre_next = RW'(p_rr) - RW'(p_ii);
        dim_next = RW'(p_ir) + RW'(p_ri);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctrl.valid <= 1'b0;
    end else begin
      b_ctrl.valid <= a_ctrl.valid;
    end
    b_ctrl.cmd    <= a_ctrl.cmd;
    b_ctrl.frac   <= a_ctrl.frac;
    b_ctrl.dz     <= 1'b0;
    b_ctrl.neg_re <= 1'b0;
    b_ctrl.neg_im <= 1'b0;
    b_nr  <= RW'(p_rr) + RW'(p_ii);
    b_ni  <= RW'(p_ir) - RW'(p_ri);
    b_den <= $unsigned(p_bbr) + $unsigned(p_bbi);
    b_dre <= dre_next;
    b_dim <= dim_next;
  end

  // Stage C: sign and magnitude of each numerator, divider seed, zero check.
  logic [PW-1:0] mag_re, mag_im;

  always_comb begin
    mag_re = b_nr[RW-1] ? PW'(-b_nr) : PW'(b_nr);
    mag_im = b_ni[RW-1] ? PW'(-b_ni) : PW'(b_ni);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= b_ctrl.valid;
    end
    ctrl.cmd    <= b_ctrl.cmd;
    ctrl.frac   <= b_ctrl.frac;
    ctrl.dz     <= (b_ctrl.cmd == CMD_DIV) && (b_den == '0);
    ctrl.neg_re <= b_nr[RW-1];
    ctrl.neg_im <= b_ni[RW-1];
    direct_re   <= b_dre;
    direct_im   <= b_dim;
    // The top half of the magnitude is already below the divisor.
    rem_re      <= {{W{1'b0}}, mag_re[PW-1:W]};
    rem_im      <= {{W{1'b0}}, mag_im[PW-1:W]};
    rest_re     <= {mag_re[W-1:0], {W{1'b0}}};
    rest_im     <= {mag_im[W-1:0], {W{1'b0}}};
    den         <= b_den;
  end

endmodule

// ===== sv/cfau_div_step.sv =====
// One restoring division step for both parts, with the side payload carried along.
module cfau_div_step
  import cfau_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl_in,
  input  logic signed [2*W:0] dre_in,
  input  logic signed [2*W:0] dim_in,
  input  logic [2*W-1:0]      rem_re_in,
  input  logic [2*W-1:0]      rem_im_in,
  input  logic [2*W-1:0]      rest_re_in,
  input  logic [2*W-1:0]      rest_im_in,
  input  logic [2*W-1:0]      q_re_in,
  input  logic [2*W-1:0]      q_im_in,
  input  logic [2*W-1:0]      den_in,
  output ctrl_t               ctrl_out,
  output logic signed [2*W:0] dre_out,
  output logic signed [2*W:0] dim_out,
  output logic [2*W-1:0]      rem_re_out,
  output logic [2*W-1:0]      rem_im_out,
  output logic [2*W-1:0]      rest_re_out,
  output logic [2*W-1:0]      rest_im_out,
  output logic [2*W-1:0]      q_re_out,
  output logic [2*W-1:0]      q_im_out,
  output logic [2*W-1:0]      den_out
);

  localparam int PW = 2 * W;

  // Shift in the next dividend bit and subtract the divisor where it fits.
  logic [PW:0]   t_re, t_im;
  logic          fit_re, fit_im;
  logic [PW-1:0] rem_re_next, rem_im_next;

  always_comb begin
    t_re        = {rem_re_in, rest_re_in[PW-1]};
    t_im        = {rem_im_in, rest_im_in[PW-1]};
    fit_re      = t_re >= {1'b0, den_in};
    fit_im      = t_im >= {1'b0, den_in};
    rem_re_next = fit_re ? PW'(t_re - {1'b0, den_in}) : PW'(t_re);
    rem_im_next = fit_im ? PW'(t_im - {1'b0, den_in}) : PW'(t_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    ctrl_out.cmd    <= ctrl_in.cmd;
    ctrl_out.frac   <= ctrl_in.frac;
    ctrl_out.dz     <= ctrl_in.dz;
    ctrl_out.neg_re <= ctrl_in.neg_re;
    ctrl_out.neg_im <= ctrl_in.neg_im;
    dre_out         <= dre_in;
    dim_out         <= dim_in;
    rem_re_out      <= rem_re_next;
    rem_im_out      <= rem_im_next;
    rest_re_out     <= rest_re_in << 1;
    rest_im_out     <= rest_im_in << 1;
    q_re_out        <= {q_re_in[PW-2:0], fit_re};
    q_im_out        <= {q_im_in[PW-2:0], fit_im};
    den_out         <= den_in;
  end

endmodule

// ===== sv/complex_fixed_arith_unit.sv =====
// Top level of the complex fixed-point arithmetic unit: front stages, divider chain, output.
//
//  channel  direction  handshake               payload
//  command  in         start, busy             command, lhs_re, lhs_im, rhs_re, rhs_im
//  config   in         cfg_valid, cfg_ready    cfg_index, cfg_data
//  result   out        done (one-cycle strobe) out_real, out_imag, out_fraction_bits,
//                                              divide_by_zero
//
// Every command beat gives one result beat, passing through the three front stages, one
// divider stage per quotient bit and the output register. A new beat is taken in every
// cycle; busy stays low.
// Reset clears the valid bits of all stages and sets both fraction registers to 8.
// The receiver cannot stall, so the pipeline never holds.
module complex_fixed_arith_unit
  import cfau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command,
  input  logic signed [FIELD_W-1:0] lhs_re,
  input  logic signed [FIELD_W-1:0] lhs_im,
  input  logic signed [FIELD_W-1:0] rhs_re,
  input  logic signed [FIELD_W-1:0] rhs_im,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [REG_W-1:0]         cfg_data,
  output logic                     done,
  output logic signed [OUT_W-1:0]  out_real,
  output logic signed [OUT_W-1:0]  out_imag,
  output logic [FRAC_W-1:0]        out_fraction_bits,
  output logic                     divide_by_zero
);

  localparam int W   = OPERAND_WIDTH;
  localparam int RW  = 2 * W + 1;
  localparam int PW  = 2 * W;
  localparam int NST = 2 * W;
  localparam int LAT = 2 * W + 4;

  // Configuration registers; writes are always taken.
  logic [REG_W-1:0] lhs_fraction_bits;
  logic [REG_W-1:0] rhs_fraction_bits;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lhs_fraction_bits <= FRAC_RESET;
      rhs_fraction_bits <= FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LHS_FRAC: lhs_fraction_bits <= cfg_data;
        REG_RHS_FRAC: rhs_fraction_bits <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Operands: the low OPERAND_WIDTH bits of each field; a wider OPERAND_WIDTH zero-extends the field.
  logic signed [W-1:0] ar, ai, br, bi;

  generate
    if (W <= FIELD_W) begin : g_narrow
      assign ar = lhs_re[W-1:0];
      assign ai = lhs_im[W-1:0];
      assign br = rhs_re[W-1:0];
      assign bi = rhs_im[W-1:0];
    end else begin : g_wide
      assign ar = W'($unsigned(lhs_re));
      assign ai = W'($unsigned(lhs_im));
      assign br = W'($unsigned(rhs_re));
      assign bi = W'($unsigned(rhs_im));
    end
  endgenerate

  // Divider chain links; link 0 comes from the front stages.
  ctrl_t                ch_ctrl    [0:NST];
  logic signed [RW-1:0] ch_dre     [0:NST];
  logic signed [RW-1:0] ch_dim     [0:NST];
  logic [PW-1:0]        ch_rem_re  [0:NST];
  logic [PW-1:0]        ch_rem_im  [0:NST];
  logic [PW-1:0]        ch_rest_re [0:NST];
  logic [PW-1:0]        ch_rest_im [0:NST];
  logic [PW-1:0]        ch_q_re    [0:NST];
  logic [PW-1:0]        ch_q_im    [0:NST];
  logic [PW-1:0]        ch_den     [0:NST];

  cfau_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .cmd       (cmd_t'(command)),
    .ar        (ar),
    .ai        (ai),
    .br        (br),
    .bi        (bi),
    .lf        (lhs_fraction_bits),
    .rf        (rhs_fraction_bits),
    .ctrl      (ch_ctrl[0]),
    .direct_re (ch_dre[0]),
    .direct_im (ch_dim[0]),
    .rem_re    (ch_rem_re[0]),
    .rem_im    (ch_rem_im[0]),
    .rest_re   (ch_rest_re[0]),
    .rest_im   (ch_rest_im[0]),
    .den       (ch_den[0])
  );

  assign ch_q_re[0] = '0;
  assign ch_q_im[0] = '0;

  // One stage for each quotient bit.
  generate
    for (genvar s = 0; s < NST; s++) begin : g_div
      cfau_div_step #(.W(W)) u_step (
        .clk         (clk),
        .rst         (rst),
        .ctrl_in     (ch_ctrl[s]),
        .dre_in      (ch_dre[s]),
        .dim_in      (ch_dim[s]),
        .rem_re_in   (ch_rem_re[s]),
        .rem_im_in   (ch_rem_im[s]),
        .rest_re_in  (ch_rest_re[s]),
        .rest_im_in  (ch_rest_im[s]),
        .q_re_in     (ch_q_re[s]),
        .q_im_in     (ch_q_im[s]),
        .den_in      (ch_den[s]),
        .ctrl_out    (ch_ctrl[s+1]),
        .dre_out     (ch_dre[s+1]),
        .dim_out     (ch_dim[s+1]),
        .rem_re_out  (ch_rem_re[s+1]),
        .rem_im_out  (ch_rem_im[s+1]),
        .rest_re_out (ch_rest_re[s+1]),
        .rest_im_out (ch_rest_im[s+1]),
        .q_re_out    (ch_q_re[s+1]),
        .q_im_out    (ch_q_im[s+1]),
        .den_out     (ch_den[s+1])
      );
    end
  endgenerate

  // Final selection: signed quotient, zeros on a zero divisor, or the direct result.
  ctrl_t                fin;
  logic signed [RW-1:0] qx_re, qx_im;
  logic signed [RW-1:0] res_re, res_im;
  logic signed [OUT_W-1:0] ext_re, ext_im;

  assign fin = ch_ctrl[NST];

  always_comb begin
    qx_re = $signed({1'b0, ch_q_re[NST]});
    qx_im = $signed({1'b0, ch_q_im[NST]});
    if (fin.cmd == CMD_DIV) begin
      if (fin.dz) begin
        res_re = '0;
        res_im = '0;
      end else begin
        res_re = fin.neg_re ? -qx_re : qx_re;
        res_im = fin.neg_im ? -qx_im : qx_im;
      end
    end else begin
      res_re = ch_dre[NST];
      res_im = ch_dim[NST];
    end
  end

  generate
    if (RW >= OUT_W) begin : g_trunc
      assign ext_re = res_re[OUT_W-1:0];
      assign ext_im = res_im[OUT_W-1:0];
    end else begin : g_sext
      assign ext_re = OUT_W'(res_re);
      assign ext_im = OUT_W'(res_im);
    end
  endgenerate

  // Output register: one strobe per result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_real          <= ext_re;
    out_imag          <= ext_im;
    out_fraction_bits <= fin.frac;
    divide_by_zero    <= fin.dz;
  end

`ifndef SYNTHESIS
  // A zero divisor always gives zero parts.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && divide_by_zero |-> (out_real == '0) && (out_imag == '0))
    else $error("zero divisor result is not zero");

  // Every result beat comes from a command beat a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without matching command beat");

  // A command beat is always followed by its result beat.
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT (done || $past(rst, LAT - 1)))
    else $error("command beat lost");

  // The block never refuses a command beat.
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
`endif

endmodule

// ===== tb/sv/complex_fixed_arith_unit_check.sv =====
// Checker of the complex fixed-point arithmetic unit: predicts every result beat and compares.
module complex_fixed_arith_unit_check
  import cfau_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                command,
  input  logic signed [FIELD_W-1:0] lhs_re,
  input  logic signed [FIELD_W-1:0] lhs_im,
  input  logic signed [FIELD_W-1:0] rhs_re,
  input  logic signed [FIELD_W-1:0] rhs_im,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]          cfg_data,
  input  logic                      done,
  input  logic signed [OUT_W-1:0]   out_real,
  input  logic signed [OUT_W-1:0]   out_imag,
  input  logic [FRAC_W-1:0]         out_fraction_bits,
  input  logic                      divide_by_zero,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPW = 16;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic [FRAC_W-1:0]       frac;
    logic                    dz;
  } cplx_result_t;

  cplx_result_t result_queue[$];
  logic [REG_W-1:0] lhs_frac;
  logic [REG_W-1:0] rhs_frac;

  // Scaled quotient of a signed numerator by a positive denominator, truncated toward zero.
  function automatic longint scaled_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< OPW) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Complex arithmetic of one command beat at the current fraction formats.
  function automatic cplx_result_t compute_result(cmd_t cmd, logic signed [FIELD_W-1:0] lr,
      logic signed [FIELD_W-1:0] li, logic signed [FIELD_W-1:0] rr,
      logic signed [FIELD_W-1:0] ri, logic [REG_W-1:0] lf, logic [REG_W-1:0] rf);
    cplx_result_t r;
    longint ar, ai, br, bi, re, im, den, mf, fr;
    ar = lr; ai = li; br = rr; bi = ri;
    re = 0; im = 0; r.dz = 1'b0;
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        mf = (lf > rf) ? lf : rf;
        ar = ar <<< (mf - lf); ai = ai <<< (mf - lf);
        br = br <<< (mf - rf); bi = bi <<< (mf - rf);
        re = (cmd == CMD_ADD) ? ar + br : ar - br;
        im = (cmd == CMD_ADD) ? ai + bi : ai - bi;
        fr = mf;
      end
      CMD_MUL: begin
        re = ar * br - ai * bi;
        im = ai * br + ar * bi;
        fr = longint'(lf) + longint'(rf);
      end
      default: begin
        den = br * br + bi * bi;
        fr = longint'(lf) + OPW - longint'(rf);
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          re = scaled_div(ar * br + ai * bi, den);
          im = scaled_div(ai * br - ar * bi, den);
        end
      end
    endcase
    r.re = re[OUT_W-1:0];
    r.im = im[OUT_W-1:0];
    r.frac = fr[FRAC_W-1:0];
    return r;
  endfunction

  // Track configuration, queue predictions, and compare result beats.
  always @(posedge clk) begin
    cplx_result_t want;
    if (rst) begin
      result_queue.delete();
      lhs_frac <= FRAC_RESET;
      rhs_frac <= FRAC_RESET;
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LHS_FRAC) lhs_frac <= cfg_data;
        else if (cfg_index == REG_RHS_FRAC) rhs_frac <= cfg_data;
      end
      if (start && !busy) begin
        result_queue.push_back(compute_result(cmd_t'(command), lhs_re, lhs_im,
                                              rhs_re, rhs_im, lhs_frac, rhs_frac));
      end
      if (done) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result beat re=%0d im=%0d", $time, out_real, out_imag);
          errors <= errors + 1;
        end else begin
          want = result_queue.pop_front();
          if (want.re !== out_real || want.im !== out_imag ||
              want.frac !== out_fraction_bits || want.dz !== divide_by_zero) begin
            $display("%0t: mismatch expected re=%0d im=%0d frac=%0d dz=%0b", $time,
                     want.re, want.im, want.frac, want.dz);
            $display("%0t:          actual   re=%0d im=%0d frac=%0d dz=%0b", $time,
                     out_real, out_imag, out_fraction_bits, divide_by_zero);
            errors <= errors + 1;
          end
        end
      end
      pending <= result_queue.size();
    end
  end
endmodule

// ===== tb/sv/complex_fixed_arith_unit_test.sv =====
// Testbench top of the complex fixed-point arithmetic unit: clock, reset, stimulus, verdict.
module complex_fixed_arith_unit_test;
  import cfau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = CMD_ADD;
  logic signed [FIELD_W-1:0] lhs_re = '0, lhs_im = '0, rhs_re = '0, rhs_im = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = REG_LHS_FRAC;
  logic [REG_W-1:0] cfg_data = '0;
  logic done;
  logic signed [OUT_W-1:0] out_real, out_imag;
  logic [FRAC_W-1:0] out_fraction_bits;
  logic divide_by_zero;
  int errors, pending;
  int cycles = 0;
  bit no_idle = 1'b0;

  complex_fixed_arith_unit dut (.*);

  complex_fixed_arith_unit_check checker_i (.*);

  // Free-running clock and a cycle limit against hangs.
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("complex_fixed_arith_unit_test: done, errors");
      $finish;
    end
  end

  // Operand part biased toward the extremes.
  function automatic logic [FIELD_W-1:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return '0;
      3: return FIELD_W'($signed($urandom_range(0, 8)) - 4);
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Random idle cycles between command beats.
  task automatic idle_gap();
    int n;
    n = 0;
    while (!no_idle && $urandom_range(0, 99) < 26) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one command beat and hold it until accepted.
  task automatic send_beat(cmd_t cmd, logic [FIELD_W-1:0] lr, logic [FIELD_W-1:0] li,
                           logic [FIELD_W-1:0] rr, logic [FIELD_W-1:0] ri);
    start <= 1'b1;
    command <= cmd;
    lhs_re <= lr; lhs_im <= li; rhs_re <= rr; rhs_im <= ri;
    @(posedge clk);
    while (busy) @(posedge clk);
    idle_gap();
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One configuration beat, then the channel goes quiet before the task returns.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_formats(logic [REG_W-1:0] lf, logic [REG_W-1:0] rf);
    drain();
    write_reg(REG_LHS_FRAC, lf);
    write_reg(REG_RHS_FRAC, rf);
  endtask

  // Fraction count biased toward the ends and the middle of the range.
  function automatic logic [REG_W-1:0] pick_format();
    case ($urandom_range(0, 5))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'd31;
      default: return REG_W'($urandom);
    endcase
  endfunction

  initial begin
    cmd_t cmd;
    logic [FIELD_W-1:0] rr, ri;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats at the reset formats, then at extreme formats: extremes, every command, zero divisor.
    send_beat(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_beat(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_beat(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(CMD_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_beat(CMD_DIV, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    send_beat(CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(CMD_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send_beat(CMD_DIV, 16'h8000, 16'h7fff, 16'hffff, 16'hffff);
    send_beat(CMD_DIV, 16'h0000, 16'h0000, 16'h0003, 16'hfffb);
    set_formats(5'd0, 5'd31);
    send_beat(CMD_ADD, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_beat(CMD_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    send_beat(CMD_DIV, 16'h4000, 16'hc000, 16'h0005, 16'h0007);
    set_formats(5'd31, 5'd0);
    send_beat(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_beat(CMD_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_beat(CMD_DIV, 16'h1234, 16'h8000, 16'h8000, 16'h0000);
    set_formats(5'd16, 5'd16);
    send_beat(CMD_ADD, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
    send_beat(CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0001);
    // Writes to unused indexes must leave the formats alone.
    drain();
    write_reg(2'd2, 5'd3);
    write_reg(2'd3, 5'd5);
    send_beat(CMD_MUL, 16'h8000, 16'h7fff, 16'h0002, 16'h8000);

    // Random phases, each at its own pair of formats.
    for (int phase = 0; phase < 11; phase++) begin
      set_formats(pick_format(), pick_format());
      no_idle = (phase == 4 || phase == 5);
      for (int i = 0; i < 100; i++) begin
        cmd = cmd_t'($urandom_range(0, 3));
        rr = pick_part();
        ri = pick_part();
        if (cmd == CMD_DIV && $urandom_range(0, 9) == 0) begin
          rr = '0;
          ri = '0;
        end
        send_beat(cmd, pick_part(), pick_part(), rr, ri);
        // Mid-phase hold-off until the pipeline is empty.
        if (phase == 7 && i == 50) drain();
      end
    end
    no_idle = 1'b0;

    drain();
    if (errors == 0) begin
      $display("complex_fixed_arith_unit_test: done, clean");
    end else begin
      $display("complex_fixed_arith_unit_test: done, errors");
    end
    $finish;
  end
endmodule
